// File: rtl/flbpm_pkg.sv
package flbpm_pkg;

    localparam int LAYER_COUNT     = 4;
    localparam int LATCH_COUNT     = 13;
    localparam int LAYER_ROM_BYTES = 8192;
    localparam int BANK_AW         = $clog2(LAYER_ROM_BYTES);

    localparam logic [2:0] FN_LATCH = 3'd0;
    localparam logic [2:0] FN_LINE  = 3'd1;
    localparam logic [2:0] FN_TICK  = 3'd2;
    localparam logic [2:0] FN_ROM   = 3'd3;
    localparam logic [2:0] FN_MIX   = 3'd4;

    typedef struct packed {
        logic                        valid;
        logic [LAYER_COUNT-1:0]      live;
        logic [LAYER_COUNT-1:0][1:0] k;
        logic [3:0]                  bank;
        logic [3:0]                  group;
    } t_fetch;

    typedef logic [LAYER_COUNT-1:0][BANK_AW-1:0] t_rom_addr;
    typedef logic [LAYER_COUNT-1:0][7:0]         t_rom_data;

endpackage

// File: rtl/flbpm_layer_ctl.sv
module flbpm_layer_ctl
    import flbpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_flip_mode_we,
    input  logic       i_flip_mode,
    input  logic       i_acc,
    input  logic [2:0] i_func,
    input  logic [3:0] i_latch_index,
    input  logic [7:0] i_write_data,
    output t_fetch     o_fetch,
    output t_rom_addr  o_rom_addr
);

    logic [7:0] r_latch [LATCH_COUNT];
    logic [7:0] r_xpos  [LAYER_COUNT];
    logic [7:0] r_row   [LAYER_COUNT];
    logic [4:0] r_start [LAYER_COUNT];
    logic [4:0] r_stop  [LAYER_COUNT];
    logic [3:0] r_mbank;
    logic [3:0] r_group;
    logic       r_flip;

    logic [7:0] n_xpos [LAYER_COUNT];
    logic       n_step [LAYER_COUNT];

    always_comb begin
        for (int i = 0; i < LAYER_COUNT; i++) begin
            if (r_flip) begin
                n_step[i] = (r_xpos[i][4:0] == 5'd0);
                n_xpos[i] = r_xpos[i] - 8'd1;
            end else begin
                n_xpos[i] = r_xpos[i] + 8'd1;
                n_step[i] = (n_xpos[i][4:0] == 5'd0);
            end
            o_fetch.live[i] = (r_start[i][4] ^ r_stop[i][4]) & ~r_xpos[i][7];
            o_fetch.k[i]    = r_xpos[i][1:0];
            o_rom_addr[i]   = {r_row[i], r_xpos[i][6:2]};
        end
        o_fetch.valid = i_acc && (i_func == FN_TICK);
        o_fetch.bank  = r_mbank;
        o_fetch.group = r_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < LATCH_COUNT; j++) begin
                r_latch[j] <= '0;
            end
            for (int i = 0; i < LAYER_COUNT; i++) begin
                r_xpos[i]  <= '0;
                r_row[i]   <= '0;
                r_start[i] <= '0;
                r_stop[i]  <= '0;
            end
            r_mbank <= '0;
            r_group <= '0;
            r_flip  <= 1'b0;
        end else begin
            if (i_flip_mode_we) begin
                r_flip <= i_flip_mode;
            end
            if (i_acc) begin
                case (i_func)
                    FN_LATCH: begin
                        if (i_latch_index < 4'(LATCH_COUNT)) begin
                            r_latch[i_latch_index] <= i_write_data;
                        end
                    end
                    FN_LINE: begin
                        for (int i = 0; i < LAYER_COUNT; i++) begin
                            r_xpos[i]  <= r_latch[2*i];
                            r_row[i]   <= r_latch[2*i+1];
                            r_start[i] <= {1'b0, r_latch[8+i][3:0]};
                            r_stop[i]  <= {1'b0, r_latch[8+i][7:4]};
                        end
                        r_mbank <= r_latch[12][3:0];
                        r_group <= r_latch[12][7:4];
                    end
                    FN_TICK: begin
                        for (int i = 0; i < LAYER_COUNT; i++) begin
                            r_xpos[i] <= n_xpos[i];
                            if (n_step[i]) begin
                                r_start[i] <= r_start[i] + 5'd1;
                                r_stop[i]  <= r_stop[i] + 5'd1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    a_line_closes_windows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_acc && i_func == FN_LINE) |=>
            (r_start[0][4] == 1'b0 && r_stop[0][4] == 1'b0 &&
             r_start[3][4] == 1'b0 && r_stop[3][4] == 1'b0))
        else $error("line start left a window counter bit 4 set");

endmodule

// File: rtl/flbpm_gfx_rom.sv
module flbpm_gfx_rom
    import flbpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_adv,
    input  t_fetch      i_fetch,
    input  t_rom_addr   i_rd_addr,
    input  logic        i_we,
    input  logic [14:0] i_wr_addr,
    input  logic [7:0]  i_wr_data,
    output t_fetch      o_fetch,
    output t_rom_data   o_rd_data
);

    t_fetch r_fetch;

    for (genvar g = 0; g < LAYER_COUNT; g++) begin : g_bank
        logic [7:0] r_mem [LAYER_ROM_BYTES];
        logic [7:0] r_q;

        always_ff @(posedge i_clk) begin
            if (i_we && i_wr_addr[14:BANK_AW] == 2'(g)) begin
                r_mem[i_wr_addr[BANK_AW-1:0]] <= i_wr_data;
            end
            if (i_adv) begin
                r_q <= r_mem[i_rd_addr[g]];
            end
        end

        assign o_rd_data[g] = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch <= '0;
        end else if (i_adv) begin
            r_fetch <= i_fetch;
        end
    end

    assign o_fetch = r_fetch;

endmodule

// File: rtl/flbpm_mix.sv
module flbpm_mix
    import flbpm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_fetch     i_fetch,
    input  t_rom_data  i_rd_data,
    input  logic       i_we,
    input  logic [7:0] i_wr_addr,
    input  logic [1:0] i_wr_data,
    input  logic       i_ready,
    output logic       o_adv,
    output logic       o_valid,
    output logic [9:0] o_pen
);

    logic [1:0] r_prom [256];
    logic [1:0] r_sel;

    logic                        r_s2_valid;
    logic [LAYER_COUNT-1:0][1:0] r_s2_pix;
    logic [3:0]                  r_s2_group;

    logic       r_out_valid;
    logic [9:0] r_pen;

    logic [LAYER_COUNT-1:0][1:0] n_pix;
    logic [LAYER_COUNT-1:0]      n_mask;
    logic [9:0]                  n_pen;

    always_comb begin
        for (int i = 0; i < LAYER_COUNT; i++) begin
            if (i_fetch.live[i]) begin
                n_pix[i] = {i_rd_data[i][{1'b1, i_fetch.k[i]}],
                            i_rd_data[i][{1'b0, i_fetch.k[i]}]};
            end else begin
                n_pix[i] = 2'd0;
            end
            n_mask[i] = |n_pix[i];
        end
        n_pen = {2'b10, r_s2_group, r_sel, r_s2_pix[r_sel]};
    end

    assign o_adv = !(r_s2_valid && r_out_valid && !i_ready);

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_prom[i_wr_addr] <= i_wr_data;
        end
        if (o_adv) begin
            r_sel <= r_prom[{i_fetch.bank, n_mask}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_s2_pix   <= n_pix;
            r_s2_group <= i_fetch.group;
        end
        if (!r_out_valid || i_ready) begin
            r_pen <= n_pen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_adv) begin
                r_s2_valid <= i_fetch.valid;
            end
            if (!r_out_valid || i_ready) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_pen   = r_pen;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_adv |-> (r_s2_valid && r_out_valid))
        else $error("pipeline stalled with a free stage");

    a_word_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && r_s2_valid) |=> r_out_valid)
        else $error("pen word dropped between stage two and output");

    a_pen_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pen[9:8] == 2'b10))
        else $error("pen outside background range");

endmodule

// File: rtl/four_layer_background_pixel_mixer.sv
// A pixel tick passes the ROM read stage, the mixer stage and the output register.
// Throughput: one word per cycle unless o_pen is stalled; set by the one read port
// of each graphics ROM bank and of the mixer PROM, each used once per tick.
// Ready drops only while both the mixer stage and the output register hold a word.
// Reset (synchronous, active low) clears latches, layer state, flip mode and valids;
// graphics ROM and mixer PROM contents are kept and are undefined until written.
module four_layer_background_pixel_mixer
    import flbpm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_flip_mode_we,
    input  logic        i_flip_mode,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_func,
    input  logic [3:0]  i_latch_index,
    input  logic [14:0] i_rom_address,
    input  logic [7:0]  i_mixer_address,
    input  logic [7:0]  i_write_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [9:0]  o_pen
);

    logic      w_adv;
    logic      w_acc;
    t_fetch    w_fetch0;
    t_fetch    w_fetch1;
    t_rom_addr w_rom_addr;
    t_rom_data w_rom_data;

    assign o_ready = w_adv;
    assign w_acc   = i_valid && w_adv;

    flbpm_layer_ctl u_layer_ctl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_flip_mode_we (i_flip_mode_we),
        .i_flip_mode    (i_flip_mode),
        .i_acc          (w_acc),
        .i_func         (i_func),
        .i_latch_index  (i_latch_index),
        .i_write_data   (i_write_data),
        .o_fetch        (w_fetch0),
        .o_rom_addr     (w_rom_addr)
    );

    flbpm_gfx_rom u_gfx_rom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_fetch   (w_fetch0),
        .i_rd_addr (w_rom_addr),
        .i_we      (w_acc && i_func == FN_ROM),
        .i_wr_addr (i_rom_address),
        .i_wr_data (i_write_data),
        .o_fetch   (w_fetch1),
        .o_rd_data (w_rom_data)
    );

    flbpm_mix u_mix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fetch   (w_fetch1),
        .i_rd_data (w_rom_data),
        .i_we      (w_acc && i_func == FN_MIX),
        .i_wr_addr (i_mixer_address),
        .i_wr_data (i_write_data[1:0]),
        .i_ready   (i_ready),
        .o_adv     (w_adv),
        .o_valid   (o_valid),
        .o_pen     (o_pen)
    );

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import flbpm_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_WORDS = 1250;

    typedef struct packed {
        bit [2:0]  func;
        bit [3:0]  latch_index;
        bit [14:0] rom_address;
        bit [7:0]  mixer_address;
        bit [7:0]  write_data;
    } t_pix_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_flip_mode_we = 1'b0;
    logic        i_flip_mode = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func = '0;
    logic [3:0]  i_latch_index = '0;
    logic [14:0] i_rom_address = '0;
    logic [7:0]  i_mixer_address = '0;
    logic [7:0]  i_write_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [9:0]  o_pen;

    four_layer_background_pixel_mixer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_flip_mode_we  (i_flip_mode_we),
        .i_flip_mode     (i_flip_mode),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_func          (i_func),
        .i_latch_index   (i_latch_index),
        .i_rom_address   (i_rom_address),
        .i_mixer_address (i_mixer_address),
        .i_write_data    (i_write_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_pen           (o_pen)
    );

    always #5 i_clk = ~i_clk;

    // mixer state as predicted
    bit [7:0] latch_model [LATCH_COUNT];
    bit [7:0] row_model   [LAYER_COUNT];
    bit [7:0] xpos_model  [LAYER_COUNT];
    bit [4:0] start_model [LAYER_COUNT];
    bit [4:0] stop_model  [LAYER_COUNT];
    bit [3:0] bank_model;
    bit [3:0] group_model;
    bit [7:0] gfx_rom_model [LAYER_COUNT * LAYER_ROM_BYTES];
    bit [1:0] mix_prom_model [256];
    bit       flip_model;

    bit [9:0] expected_pens [$];
    bit [9:0] want_pen;
    int       errors = 0;
    int       cycle_count = 0;
    int       gap_max = 0;
    int       burst_left = 0;
    bit       bus_held = 1'b0;
    int       words_sent = 0;
    bit [15:0] ready_pattern = '1;
    int       pattern_left = 0;

    function automatic bit [1:0] layer_pixel(input int ly);
        bit [7:0] col;
        bit [7:0] b;
        bit [1:0] k;
        col = xpos_model[ly];
        if (col[7]) begin
            return 2'd0;
        end
        b = gfx_rom_model[{2'(ly), row_model[ly], col[6:2]}];
        k = col[1:0];
        return {b[4 + k], b[k]};
    endfunction

    task automatic predict_word(input t_pix_word w);
        bit [1:0] pix [LAYER_COUNT];
        bit [3:0] mask;
        bit [1:0] sel;
        bit       step;
        case (w.func)
            FN_LATCH: begin
                if (w.latch_index < LATCH_COUNT) begin
                    latch_model[w.latch_index] = w.write_data;
                end
            end
            FN_LINE: begin
                for (int i = 0; i < LAYER_COUNT; i++) begin
                    xpos_model[i]  = latch_model[2 * i];
                    row_model[i]   = latch_model[2 * i + 1];
                    start_model[i] = {1'b0, latch_model[8 + i][3:0]};
                    stop_model[i]  = {1'b0, latch_model[8 + i][7:4]};
                end
                bank_model  = latch_model[12][3:0];
                group_model = latch_model[12][7:4];
            end
            FN_TICK: begin
                mask = '0;
                for (int i = 0; i < LAYER_COUNT; i++) begin
                    pix[i] = 2'd0;
                    if (start_model[i][4] ^ stop_model[i][4]) begin
                        pix[i] = layer_pixel(i);
                        mask[i] = (pix[i] != 2'd0);
                    end
                end
                sel = mix_prom_model[{bank_model, mask}];
                expected_pens.push_back({2'b10, group_model, sel, pix[sel]});
                for (int i = 0; i < LAYER_COUNT; i++) begin
                    if (flip_model) begin
                        step = (xpos_model[i][4:0] == 5'd0);
                        xpos_model[i] = xpos_model[i] - 8'd1;
                    end else begin
                        xpos_model[i] = xpos_model[i] + 8'd1;
                        step = (xpos_model[i][4:0] == 5'd0);
                    end
                    if (step) begin
                        start_model[i] = start_model[i] + 5'd1;
                        stop_model[i]  = stop_model[i] + 5'd1;
                    end
                end
            end
            FN_ROM: gfx_rom_model[w.rom_address] = w.write_data;
            FN_MIX: mix_prom_model[w.mixer_address] = w.write_data[1:0];
            default: ;
        endcase
    endtask

    function automatic t_pix_word random_word(input bit [2:0] f);
        t_pix_word w;
        w.func          = f;
        w.latch_index   = 4'($urandom);
        w.rom_address   = 15'($urandom);
        w.mixer_address = 8'($urandom);
        w.write_data    = 8'($urandom);
        return w;
    endfunction

    task automatic send_word(input t_pix_word w);
        int gap;
        @(negedge i_clk);
        if (gap_max > 0 && burst_left == 0) begin
            gap = $urandom_range(1, gap_max);
            burst_left = $urandom_range(1, 12);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        i_func          <= w.func;
        i_latch_index   <= w.latch_index;
        i_rom_address   <= w.rom_address;
        i_mixer_address <= w.mixer_address;
        i_write_data    <= w.write_data;
        i_valid         <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        predict_word(w);
        bus_held = 1'b1;
    endtask

    task automatic release_bus();
        if (bus_held) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            bus_held = 1'b0;
        end
    endtask

    task automatic write_latch(input int idx, input bit [7:0] v);
        t_pix_word w;
        w = random_word(FN_LATCH);
        w.latch_index = 4'(idx);
        w.write_data = v;
        send_word(w);
    endtask

    task automatic write_store(input bit [2:0] f, input int addr, input bit [7:0] v);
        t_pix_word w;
        w = random_word(f);
        w.rom_address = 15'(addr);
        w.mixer_address = 8'(addr);
        w.write_data = v;
        send_word(w);
    endtask

    // flip is only changed with the pipe drained
    task automatic set_flip(input bit v);
        release_bus();
        while (expected_pens.size() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
        i_flip_mode_we <= 1'b1;
        i_flip_mode <= v;
        @(negedge i_clk);
        i_flip_mode_we <= 1'b0;
        flip_model = v;
    endtask

    task automatic load_stores();
        gap_max = 0;
        for (int a = 0; a < LAYER_COUNT * LAYER_ROM_BYTES; a++) begin
            write_store(FN_ROM, a, 8'($urandom));
        end
        for (int a = 0; a < 256; a++) begin
            write_store(FN_MIX, a, 8'($urandom));
        end
    endtask

    task automatic test_directed();
        gap_max = 2;
        write_latch(LATCH_COUNT, 8'hff);
        write_latch(15, 8'hff);
        send_word(random_word(3'(int'(FN_MIX) + 1)));
        send_word(random_word(3'd7));
        write_store(FN_ROM, 15'h7fff, 8'hff);
        write_store(FN_ROM, 0, 8'h00);
        write_store(FN_MIX, 8'hff, 8'hff);
        write_store(FN_MIX, 8'h00, 8'hfe);
        // no layer present: mask zero still picks a layer
        send_word(random_word(FN_TICK));
        write_latch(0, 8'h1f);
        write_latch(1, 8'hff);
        write_latch(2, 8'hff);
        write_latch(4, 8'h9f);
        write_latch(8, 8'h0f);
        write_latch(9, 8'h0f);
        write_latch(10, 8'h0f);
        write_latch(12, 8'hff);
        send_word(random_word(FN_LINE));
        repeat (3) send_word(random_word(FN_TICK));
    endtask

    task automatic test_flip();
        set_flip(1'b1);
        gap_max = 0;
        write_latch(0, 8'h00);
        write_latch(2, 8'h80);
        write_latch(8, 8'h0f);
        write_latch(9, 8'h0f);
        send_word(random_word(FN_LINE));
        repeat (20) send_word(random_word(FN_TICK));
    endtask

    function automatic bit [7:0] x_offset_value();
        case ($urandom_range(0, 2))
            0: return {3'($urandom), 5'h1f};
            1: return {3'($urandom), 5'h00};
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bit [7:0] window_value();
        if ($urandom_range(0, 1)) begin
            return {4'($urandom_range(0, 3)), 4'($urandom_range(12, 15))};
        end
        return 8'($urandom);
    endfunction

    task automatic run_scanline();
        bit [7:0]  v;
        int        n;
        if ($urandom_range(0, 9) == 0) begin
            send_word(random_word(3'($urandom_range(int'(FN_MIX) + 1, 7))));
        end
        if ($urandom_range(0, 9) == 0) begin
            write_latch($urandom_range(LATCH_COUNT, 15), 8'($urandom));
        end
        if ($urandom_range(0, 3) == 0) begin
            send_word(random_word(FN_ROM));
            words_sent++;
        end
        if ($urandom_range(0, 3) == 0) begin
            send_word(random_word(FN_MIX));
            words_sent++;
        end
        for (int i = 0; i < LATCH_COUNT; i++) begin
            if ($urandom_range(0, 1)) begin
                if (i < 8 && i % 2 == 0) begin
                    v = x_offset_value();
                end else if (i >= 8 && i < 12) begin
                    v = window_value();
                end else begin
                    v = 8'($urandom);
                end
                write_latch(i, v);
                words_sent++;
            end
        end
        send_word(random_word(FN_LINE));
        n = $urandom_range(1, 48);
        repeat (n) send_word(random_word(FN_TICK));
        words_sent += n + 1;
    endtask

    task automatic test_random();
        int phase;
        phase = 0;
        while (words_sent < RANDOM_WORDS) begin
            set_flip(phase[0]);
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 2;
                default: gap_max = 6;
            endcase
            repeat (5) run_scanline();
            phase++;
        end
    endtask

    // receiver stall pattern
    always @(negedge i_clk) begin
        if (pattern_left == 0) begin
            ready_pattern = ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom);
            pattern_left = $urandom_range(16, 96);
        end
        pattern_left--;
        i_ready <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_pens.size() == 0) begin
                $error("pen: expected none, actual %0h", o_pen);
                errors++;
            end else begin
                want_pen = expected_pens.pop_front();
                if (o_pen !== want_pen) begin
                    $error("pen: expected %0h, actual %0h", want_pen, o_pen);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("four_layer_background_pixel_mixer: mismatch");
            $finish;
        end
    end

    initial begin
        foreach (latch_model[i]) latch_model[i] = '0;
        foreach (row_model[i]) begin
            row_model[i] = '0;
            xpos_model[i] = '0;
            start_model[i] = '0;
            stop_model[i] = '0;
        end
        bank_model = '0;
        group_model = '0;
        flip_model = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_flip(1'b0);
        load_stores();
        test_directed();
        test_flip();
        test_random();
        release_bus();
        while (expected_pens.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("four_layer_background_pixel_mixer: match");
        end else begin
            $display("four_layer_background_pixel_mixer: mismatch");
        end
        $finish;
    end

endmodule
